/* src/bpseq_pkg.sv */
// Package for the buzzer pattern sequencer: codes, state and item types,
// and the constant beep pattern table.
// Depends on nothing.
`timescale 1ns / 1ps

package bpseq_pkg;

    // Item kinds on the input channel.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_PLAY = 1'b1;

    // Sound codes: none, first and last stored sequence.
    localparam logic [3:0] SND_NONE  = 4'd0;
    localparam logic [3:0] SND_FIRST = 4'd1;
    localparam logic [3:0] SND_LAST  = 4'd14;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TONE  = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    // One request as held in the input register.
    typedef struct packed {
        logic       mode;
        logic [3:0] sound;
    } item_t;

    // One step of a beep sequence.
    typedef struct packed {
        logic [8:0] tone;
        logic [8:0] pause;
        logic [2:0] rep;
    } beep_step_t;

    // Sequencer state carried from one request to the next.
    typedef struct packed {
        logic [3:0] active_sound;
        logic [2:0] step_number;
        logic [2:0] repeats_left;
        phase_t     phase;
        logic [8:0] time_left;
        logic       running;
        logic       pin_level;
    } seq_state_t;

    localparam seq_state_t STATE_HALTED = '{
        active_sound: 4'd0,
        step_number:  3'd0,
        repeats_left: 3'd0,
        phase:        PH_IDLE,
        time_left:    9'd0,
        running:      1'b0,
        pin_level:    1'b0
    };

    function automatic beep_step_t mk_step(input logic [8:0] tone,
                                           input logic [8:0] pause,
                                           input logic [2:0] rep);
        beep_step_t s;
        s.tone  = tone;
        s.pause = pause;
        s.rep   = rep;
        return s;
    endfunction

    // Pattern table. Any sound or step outside the stored rows reads as the
    // all-zero end step.
    function automatic beep_step_t rom_step(input logic [3:0] sound,
                                            input logic [2:0] step);
        beep_step_t s;
        s = '0;
        case (sound)
            4'd1:  if (step == 3'd0) s = mk_step(9'd100, 9'd0, 3'd1);
            4'd2:  if (step == 3'd0) s = mk_step(9'd80, 9'd80, 3'd2);
            4'd3:  if (step == 3'd0) s = mk_step(9'd60, 9'd60, 3'd2);
            4'd4:  if (step == 3'd0) s = mk_step(9'd100, 9'd0, 3'd1);
            4'd5:  if (step == 3'd0) s = mk_step(9'd60, 9'd60, 3'd3);
            4'd6:  if (step == 3'd0) s = mk_step(9'd500, 9'd0, 3'd1);
            4'd7: begin
                case (step)
                    3'd0:    s = mk_step(9'd80, 9'd40, 3'd1);
                    3'd1:    s = mk_step(9'd160, 9'd40, 3'd1);
                    3'd2:    s = mk_step(9'd80, 9'd0, 3'd1);
                    default: s = '0;
                endcase
            end
            4'd8: begin
                case (step)
                    3'd0:    s = mk_step(9'd180, 9'd40, 3'd1);
                    3'd1:    s = mk_step(9'd80, 9'd0, 3'd1);
                    default: s = '0;
                endcase
            end
            4'd9: begin
                case (step)
                    3'd0:    s = mk_step(9'd40, 9'd20, 3'd1);
                    3'd1:    s = mk_step(9'd60, 9'd20, 3'd1);
                    3'd2:    s = mk_step(9'd80, 9'd20, 3'd1);
                    3'd3:    s = mk_step(9'd100, 9'd20, 3'd1);
                    3'd4:    s = mk_step(9'd140, 9'd120, 3'd1);
                    default: s = '0;
                endcase
            end
            4'd10: begin
                case (step)
                    3'd0:    s = mk_step(9'd140, 9'd30, 3'd1);
                    3'd1:    s = mk_step(9'd100, 9'd30, 3'd1);
                    3'd2:    s = mk_step(9'd80, 9'd30, 3'd1);
                    3'd3:    s = mk_step(9'd60, 9'd30, 3'd1);
                    3'd4:    s = mk_step(9'd40, 9'd200, 3'd1);
                    default: s = '0;
                endcase
            end
            4'd11: if (step == 3'd0) s = mk_step(9'd50, 9'd30, 3'd3);
            4'd12: if (step == 3'd0) s = mk_step(9'd40, 9'd20, 3'd4);
            4'd13: begin
                case (step)
                    3'd0:    s = mk_step(9'd50, 9'd40, 3'd3);
                    3'd1:    s = mk_step(9'd120, 9'd0, 3'd1);
                    default: s = '0;
                endcase
            end
            4'd14: if (step == 3'd0) s = mk_step(9'd30, 9'd0, 3'd1);
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

/* src/buzzer_pattern_sequencer_core.sv */
// Top level of the buzzer pattern sequencer: input register, state and
// result registers. Uses bpseq_pkg, bpseq_in_reg and bpseq_next.
//
//   Channel  Ports                        Carries
//   -------  ---------------------------  ---------------------------------
//   input    s_valid s_ready s_mode       one tick or play request
//            s_sound
//   result   m_valid m_ready m_buzzer_on  pin level and busy flag after
//            m_busy_res                   each request
//
// Each request passes first through the input register, then through the
// state update into the result register. One request is accepted every
// cycle while results are taken. Reset (aresetn low, synchronous) empties
// both registers and halts the sequencer silent; the m_buzzer_on register
// itself is not reset. A stalled result holds the update stage, and the
// input register then fills and drops s_ready.
`timescale 1ns / 1ps

module buzzer_pattern_sequencer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [3:0] s_sound,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_buzzer_on,
    output logic       m_busy_res
);
    import bpseq_pkg::*;

    logic       item_valid;
    item_t      item;
    logic       advance;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       out_valid_reg;
    logic       out_buzzer_reg;
    logic       out_busy_reg;

    // The update stage moves when the result register is free or drained.
    assign advance = item_valid && (!out_valid_reg || m_ready);

    bpseq_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_sound    (s_sound),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bpseq_next u_next (
        .item (item),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // Sequencer state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_HALTED;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_buzzer_reg <= state_next.pin_level;
            out_busy_reg   <= state_next.running;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_buzzer_on = out_buzzer_reg;
    assign m_busy_res  = out_busy_reg;

endmodule

/* src/bpseq_in_reg.sv */
// Input register of the buzzer pattern sequencer: holds one accepted
// request until the update stage takes it. Uses bpseq_pkg.
`timescale 1ns / 1ps

module bpseq_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [3:0]          s_sound,
    input  logic                take,
    output logic                item_valid,
    output bpseq_pkg::item_t    item
);
    import bpseq_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register may refill in the same cycle as it is drained.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mode  <= s_mode;
            item_reg.sound <= s_sound;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* src/bpseq_next.sv */
// Next-state logic of the buzzer pattern sequencer: applies one play or
// tick request to the current state. Uses bpseq_pkg and its pattern table.
`timescale 1ns / 1ps

module bpseq_next (
    input  bpseq_pkg::item_t      item,
    input  bpseq_pkg::seq_state_t cur,
    output bpseq_pkg::seq_state_t nxt
);
    import bpseq_pkg::*;

    beep_step_t cur_step;
    beep_step_t following_step;
    beep_step_t first_step;
    logic [2:0] following_number;
    logic [8:0] time_dec;

    assign following_number = cur.step_number + 3'd1;
    assign cur_step         = rom_step(cur.active_sound, cur.step_number);
    assign following_step   = rom_step(cur.active_sound, following_number);
    assign first_step       = rom_step(item.sound, 3'd0);
    assign time_dec         = (cur.time_left != 9'd0) ? cur.time_left - 9'd1 : 9'd0;

    // Start a step: an all-zero step ends the sequence, otherwise tone on.
    function automatic seq_state_t begin_step(input seq_state_t st,
                                              input beep_step_t bs);
        seq_state_t r;
        r = st;
        if (bs == '0) begin
            r = STATE_HALTED;
        end else begin
            r.repeats_left = (bs.rep != 3'd0) ? bs.rep : 3'd1;
            r.phase        = PH_TONE;
            r.pin_level    = 1'b1;
            r.time_left    = bs.tone;
        end
        return r;
    endfunction

    // End of a tone/pause cycle: repeat the step or move on to the next one.
    function automatic seq_state_t after_cycle(input seq_state_t st,
                                               input beep_step_t bs,
                                               input beep_step_t nbs,
                                               input logic [2:0] nnum);
        seq_state_t r;
        r = st;
        if (st.repeats_left > 3'd1) begin
            r.repeats_left = st.repeats_left - 3'd1;
            r.phase        = PH_TONE;
            r.pin_level    = 1'b1;
            r.time_left    = bs.tone;
        end else begin
            r.step_number = nnum;
            r = begin_step(r, nbs);
        end
        return r;
    endfunction

    always_comb begin
        seq_state_t t;
        nxt = cur;
        t   = cur;
        if (item.mode == MODE_PLAY) begin
            // Stop codes clear everything; a known sound restarts its sequence.
            if (item.sound == SND_NONE || item.sound > SND_LAST) begin
                nxt = STATE_HALTED;
            end else begin
                t.active_sound = item.sound;
                t.step_number  = 3'd0;
                t.phase        = PH_IDLE;
                t.running      = 1'b1;
                nxt = begin_step(t, first_step);
            end
        end else if (cur.running) begin
            // One millisecond passes; act when the phase has run out.
            t.time_left = time_dec;
            nxt = t;
            if (time_dec == 9'd0) begin
                case (cur.phase)
                    PH_TONE: begin
                        t.pin_level = 1'b0;
                        if (cur_step.pause == 9'd0) begin
                            nxt = after_cycle(t, cur_step, following_step,
                                              following_number);
                        end else begin
                            t.phase     = PH_PAUSE;
                            t.time_left = cur_step.pause;
                            nxt = t;
                        end
                    end
                    PH_PAUSE: begin
                        nxt = after_cycle(t, cur_step, following_step,
                                          following_number);
                    end
                    default: nxt = t;
                endcase
            end
        end
    end

endmodule
